FILE: rtl/detection_box_fusion_unit_assert.svh
// Assertion macros shared by the detection box fusion RTL.
`ifndef DETECTION_BOX_FUSION_UNIT_ASSERT_SVH
`define DETECTION_BOX_FUSION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DBF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbf assertion failed");

// Next-cycle implication, disabled while in reset.
`define DBF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbf assertion failed");

`endif

FILE: rtl/dbf_pkg.sv
// Shared constants, types and controller/datapath interface for the box fusion unit.
`default_nettype none
package dbf_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int EDGE_W    = 16;
    localparam int SCORE_W   = 16;
    localparam int CLASS_W   = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_EDGES = 4;
    localparam int BOX_W     = NUM_EDGES * EDGE_W;
    localparam int REC_W     = BOX_W + SCORE_W + CLASS_W;

    localparam int PROD_W    = EDGE_W + SCORE_W;
    localparam int WGT_W     = SCORE_W + IDX_W;
    localparam int SUM_W     = PROD_W + IDX_W;
    localparam int STEP_W    = $clog2(EDGE_W + 1);

    localparam int FRAC_W    = 16;
    localparam int CEN_SHIFT = 22;

    localparam int E_LEFT   = 0;
    localparam int E_TOP    = 1;
    localparam int E_RIGHT  = 2;
    localparam int E_BOTTOM = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_RATIO    = 2'd2;

    localparam logic [CFG_W-1:0] RST_IOU_LIMIT     = 16'd29491;
    localparam logic [CFG_W-1:0] RST_CENTRE_FACTOR = 16'd737;
    localparam logic [CFG_W-1:0] RST_AREA_RATIO    = 16'd39322;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [EDGE_W-1:0]  t_edge;
    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [CLASS_W-1:0] t_class;

    // edges[0] is left, lowest bits
    typedef struct packed {
        t_class                      cls;
        t_score                      score;
        logic [NUM_EDGES-1:0][EDGE_W-1:0] edges;
    } t_rec;

    typedef struct packed {
        logic load_we;
        t_idx wr_addr;
        t_idx rd_addr;
        logic anc_latch;
        logic scan_issue;
        logic div_start;
        logic emit;
        logic batch_end;
        logic single;
    } t_cmd;

    typedef struct packed {
        logic cand_vld;
        t_idx cand_idx;
        logic pipe_busy;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/dbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/dbf_div.sv
// Restoring divider lane, one quotient bit per cycle, 16-bit quotient.
`default_nettype none
module dbf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [dbf_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [dbf_pkg::WGT_W-1:0]   i_divisor,
    output logic      [dbf_pkg::EDGE_W-1:0]  o_quot,
    output logic                             o_busy
);
    import dbf_pkg::*;

    logic [WGT_W-1:0]  r_rem;
    logic [WGT_W-1:0]  r_div;
    logic [EDGE_W-1:0] r_q;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [WGT_W:0]    n_trial;
    logic              n_bit;

    always_comb begin
        n_trial = {r_rem, r_q[EDGE_W-1]};
        n_bit   = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(EDGE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[SUM_W-1:EDGE_W];
            r_q   <= i_dividend[EDGE_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_bit ? WGT_W'(n_trial - {1'b0, r_div}) : n_trial[WGT_W-1:0];
            r_q   <= {r_q[EDGE_W-2:0], n_bit};
        end
    end

    assign o_quot = r_q;
    assign o_busy = r_busy;
endmodule
`default_nettype wire

FILE: rtl/dbf_ctrl.sv
// Sequencer for loading, cluster scans, division and result hand-off.
`default_nettype none
`include "detection_box_fusion_unit_assert.svh"
module dbf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    output dbf_pkg::t_cmd      o_cmd,
    input  wire dbf_pkg::t_sts i_sts
);
    import dbf_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD, ST_FETCH, ST_LATCH, ST_SCAN, ST_DRAIN, ST_DIV, ST_EMIT
    } t_state;

    t_state r_state;
    t_cnt   r_count;
    t_idx   r_scan;
    logic   w_in_acc;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_in_acc   = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_addr    = r_scan;
        o_cmd.wr_addr    = r_count[IDX_W-1:0];
        o_cmd.single     = (r_count == CNT_W'(1));
        o_cmd.load_we    = w_in_acc && (r_count != CNT_W'(MAX_BOXES));
        case (r_state)
            ST_FETCH: o_cmd.rd_addr    = i_sts.cand_idx;
            ST_LATCH: o_cmd.anc_latch  = 1'b1;
            ST_SCAN:  o_cmd.scan_issue = 1'b1;
            ST_DRAIN: o_cmd.div_start  = !i_sts.pipe_busy;
            ST_EMIT: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.batch_end = i_sts.out_free && !i_sts.cand_vld;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_scan  <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (o_cmd.load_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_in_last) begin
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: r_state <= ST_LATCH;
                ST_LATCH: begin
                    r_scan  <= '0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (CNT_W'(r_scan) == r_count - CNT_W'(1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_scan <= r_scan + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!i_sts.div_busy) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (i_sts.out_free) begin
                        if (i_sts.cand_vld) begin
                            r_state <= ST_FETCH;
                        end else begin
                            r_state <= ST_LOAD;
                            r_count <= '0;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    `DBF_ASSERT_IMPL(a_merge_nonempty, i_clk, i_rst_n, r_state != ST_LOAD, r_count != '0)
    `DBF_ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n, r_state == ST_SCAN, CNT_W'(r_scan) < r_count)
    `DBF_ASSERT_IMPL(a_fetch_has_anchor, i_clk, i_rst_n, r_state == ST_FETCH, i_sts.cand_vld)
endmodule
`default_nettype wire

FILE: rtl/dbf_dp.sv
// Datapath: detection store, match pipeline, cluster accumulators, dividers, output register.
`default_nettype none
`include "detection_box_fusion_unit_assert.svh"
module dbf_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dbf_pkg::t_cmd                 i_cmd,
    output dbf_pkg::t_sts                      o_sts,
    input  wire logic [dbf_pkg::REC_W-1:0]     i_in_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [dbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dbf_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [dbf_pkg::REC_W-1:0]     o_out_data,
    output logic                               o_out_last
);
    import dbf_pkg::*;

    localparam int XS_W     = EDGE_W + 1;
    localparam int SQ_W     = 2 * XS_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int UNI_W    = PROD_W + 1;
    localparam int SIDE_W   = PROD_W + 1;
    localparam int F2_W     = 2 * CFG_W;
    localparam int SPLIT_W  = (SIDE_W + 1) / 2;
    localparam int CLO_W    = SPLIT_W + F2_W;
    localparam int CHI_W    = SIDE_W - SPLIT_W + F2_W;
    localparam int CEN_W    = CHI_W + SPLIT_W;
    localparam int IOU_W    = CFG_W + UNI_W;
    localparam int AREA_W   = CFG_W + PROD_W;
    localparam int NSTAGE   = 7;

    typedef logic [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic                            uncons;
        logic                            cls_eq;
        t_idx                            idx;
        t_score                          score;
        logic [NUM_EDGES-1:0][PROD_W-1:0] pe;
    } t_car;

    typedef struct packed {
        t_edge iw, ih, a0w, a0h, b0w, b0h, aw, ah, bw, bh, mw, mh;
        logic [XS_W-1:0] ux, uy;
        logic   uncons;
        logic   cls_eq;
        t_idx   idx;
        t_score score;
        logic [NUM_EDGES-1:0][EDGE_W-1:0] edges;
    } t_s1;

    typedef struct packed {
        t_prod inter, aa, ab, ga, gb, mw2, mh2;
        logic [SQ_W-1:0] ux2, uy2;
        t_car car;
    } t_s2;

    typedef struct packed {
        t_prod inter;
        logic [UNI_W-1:0]  uni;
        logic [DIST_W-1:0] dist2;
        logic [SIDE_W-1:0] side2;
        t_prod small_a, large_a;
        t_car car;
    } t_s3;

    typedef struct packed {
        t_prod inter;
        logic  uni_nz;
        logic [IOU_W-1:0]  iou_rhs;
        logic [DIST_W-1:0] dist2;
        logic [CLO_W-1:0]  cen_lo;
        logic [CHI_W-1:0]  cen_hi;
        t_prod small_a;
        logic [AREA_W-1:0] area_rhs;
        t_car car;
    } t_s4;

    typedef struct packed {
        logic iou_ok;
        logic area_ok;
        logic [DIST_W-1:0] dist2;
        logic [CEN_W-1:0]  cen_rhs;
        t_car car;
    } t_s5;

    typedef struct packed {
        logic member;
        t_car car;
    } t_s6;

    function automatic t_edge min_e(t_edge x, t_edge y);
        return (x < y) ? x : y;
    endfunction

    function automatic t_edge max_e(t_edge x, t_edge y);
        return (x > y) ? x : y;
    endfunction

    function automatic t_edge pos_diff(t_edge hi, t_edge lo);
        return (hi > lo) ? t_edge'(hi - lo) : '0;
    endfunction

    function automatic t_edge at_least_one(t_edge v);
        return (v == '0) ? EDGE_W'(1) : v;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_iou_lim, r_cen_fac, r_area_lim;
    logic [F2_W-1:0]  r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_lim  <= RST_IOU_LIMIT;
            r_cen_fac  <= RST_CENTRE_FACTOR;
            r_area_lim <= RST_AREA_RATIO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IOU_LIMIT:     r_iou_lim  <= i_cfg_data;
                CFG_CENTRE_FACTOR: r_cen_fac  <= i_cfg_data;
                CFG_AREA_RATIO:    r_area_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2 <= F2_W'(r_cen_fac) * F2_W'(r_cen_fac);
    end

    // detection store
    logic [REC_W-1:0] w_rd;
    t_rec             w_rec;
    t_rec             w_in_rec;

    dbf_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_in_data),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rd)
    );

    assign w_rec    = t_rec'(w_rd);
    assign w_in_rec = t_rec'(i_in_data);

    logic [MAX_BOXES-1:0] r_cons;
    logic                 r_cons_rd;
    t_idx                 r_idx0;
    logic [NSTAGE-1:0]    r_vld;
    t_rec                 r_anc;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;

    logic [XS_W-1:0] w_sa, w_sb, w_ta, w_tb;

    always_comb begin
        w_sa = {1'b0, r_anc.edges[E_LEFT]} + {1'b0, r_anc.edges[E_RIGHT]};
        w_sb = {1'b0, w_rec.edges[E_LEFT]} + {1'b0, w_rec.edges[E_RIGHT]};
        w_ta = {1'b0, r_anc.edges[E_TOP]} + {1'b0, r_anc.edges[E_BOTTOM]};
        w_tb = {1'b0, w_rec.edges[E_TOP]} + {1'b0, w_rec.edges[E_BOTTOM]};

        n_s1.iw  = pos_diff(min_e(r_anc.edges[E_RIGHT], w_rec.edges[E_RIGHT]),
                            max_e(r_anc.edges[E_LEFT], w_rec.edges[E_LEFT]));
        n_s1.ih  = pos_diff(min_e(r_anc.edges[E_BOTTOM], w_rec.edges[E_BOTTOM]),
                            max_e(r_anc.edges[E_TOP], w_rec.edges[E_TOP]));
        n_s1.a0w = pos_diff(r_anc.edges[E_RIGHT], r_anc.edges[E_LEFT]);
        n_s1.a0h = pos_diff(r_anc.edges[E_BOTTOM], r_anc.edges[E_TOP]);
        n_s1.b0w = pos_diff(w_rec.edges[E_RIGHT], w_rec.edges[E_LEFT]);
        n_s1.b0h = pos_diff(w_rec.edges[E_BOTTOM], w_rec.edges[E_TOP]);
        n_s1.aw  = at_least_one(n_s1.a0w);
        n_s1.ah  = at_least_one(n_s1.a0h);
        n_s1.bw  = at_least_one(n_s1.b0w);
        n_s1.bh  = at_least_one(n_s1.b0h);
        n_s1.mw  = min_e(n_s1.aw, n_s1.bw);
        n_s1.mh  = min_e(n_s1.ah, n_s1.bh);
        n_s1.ux  = (w_sa > w_sb) ? XS_W'(w_sa - w_sb) : XS_W'(w_sb - w_sa);
        n_s1.uy  = (w_ta > w_tb) ? XS_W'(w_ta - w_tb) : XS_W'(w_tb - w_ta);
        n_s1.uncons = !r_cons_rd;
        n_s1.cls_eq = (w_rec.cls == r_anc.cls);
        n_s1.idx    = r_idx0;
        n_s1.score  = w_rec.score;
        n_s1.edges  = w_rec.edges;
    end

    always_comb begin
        n_s2.inter = t_prod'(r_s1.iw) * t_prod'(r_s1.ih);
        n_s2.aa    = t_prod'(r_s1.a0w) * t_prod'(r_s1.a0h);
        n_s2.ab    = t_prod'(r_s1.b0w) * t_prod'(r_s1.b0h);
        n_s2.ga    = t_prod'(r_s1.aw) * t_prod'(r_s1.ah);
        n_s2.gb    = t_prod'(r_s1.bw) * t_prod'(r_s1.bh);
        n_s2.mw2   = t_prod'(r_s1.mw) * t_prod'(r_s1.mw);
        n_s2.mh2   = t_prod'(r_s1.mh) * t_prod'(r_s1.mh);
        n_s2.ux2   = SQ_W'(r_s1.ux) * SQ_W'(r_s1.ux);
        n_s2.uy2   = SQ_W'(r_s1.uy) * SQ_W'(r_s1.uy);
        n_s2.car.uncons = r_s1.uncons;
        n_s2.car.cls_eq = r_s1.cls_eq;
        n_s2.car.idx    = r_s1.idx;
        n_s2.car.score  = r_s1.score;
        for (int j = 0; j < NUM_EDGES; j++) begin
            n_s2.car.pe[j] = t_prod'(r_s1.score) * t_prod'(r_s1.edges[j]);
        end
    end

    always_comb begin
        n_s3.inter   = r_s2.inter;
        n_s3.uni     = UNI_W'(r_s2.aa) + UNI_W'(r_s2.ab) - UNI_W'(r_s2.inter);
        n_s3.dist2   = DIST_W'(r_s2.ux2) + DIST_W'(r_s2.uy2);
        n_s3.side2   = SIDE_W'(r_s2.mw2) + SIDE_W'(r_s2.mh2);
        n_s3.small_a = (r_s2.ga < r_s2.gb) ? r_s2.ga : r_s2.gb;
        n_s3.large_a = (r_s2.ga < r_s2.gb) ? r_s2.gb : r_s2.ga;
        n_s3.car     = r_s2.car;
    end

    always_comb begin
        n_s4.inter    = r_s3.inter;
        n_s4.uni_nz   = (r_s3.uni != '0);
        n_s4.iou_rhs  = IOU_W'(r_iou_lim) * IOU_W'(r_s3.uni);
        n_s4.dist2    = r_s3.dist2;
        n_s4.cen_lo   = CLO_W'(r_s3.side2[SPLIT_W-1:0]) * CLO_W'(r_f2);
        n_s4.cen_hi   = CHI_W'(r_s3.side2[SIDE_W-1:SPLIT_W]) * CHI_W'(r_f2);
        n_s4.small_a  = r_s3.small_a;
        n_s4.area_rhs = AREA_W'(r_area_lim) * AREA_W'(r_s3.large_a);
        n_s4.car      = r_s3.car;
    end

    always_comb begin
        n_s5.iou_ok  = (r_iou_lim == '0) ||
                       (r_s4.uni_nz &&
                        (IOU_W'({r_s4.inter, {FRAC_W{1'b0}}}) >= r_s4.iou_rhs));
        n_s5.area_ok = ({r_s4.small_a, {FRAC_W{1'b0}}} >= r_s4.area_rhs);
        n_s5.dist2   = r_s4.dist2;
        n_s5.cen_rhs = {r_s4.cen_hi, {SPLIT_W{1'b0}}} + CEN_W'(r_s4.cen_lo);
        n_s5.car     = r_s4.car;
    end

    always_comb begin
        n_s6.member = r_s5.car.uncons && r_s5.car.cls_eq &&
                      (r_s5.iou_ok ||
                       ((CEN_W'({r_s5.dist2, {CEN_SHIFT{1'b0}}}) <= r_s5.cen_rhs) &&
                        r_s5.area_ok));
        n_s6.car    = r_s5.car;
    end

    always_ff @(posedge i_clk) begin
        r_cons_rd <= r_cons[i_cmd.rd_addr];
        r_idx0    <= i_cmd.rd_addr;
        r_s1      <= n_s1;
        r_s2      <= n_s2;
        r_s3      <= n_s3;
        r_s4      <= n_s4;
        r_s5      <= n_s5;
        r_s6      <= n_s6;
        if (i_cmd.anc_latch) begin
            r_anc <= w_rec;
        end
    end

    // accumulators and next-anchor candidate
    logic [WGT_W-1:0]                 r_wgt;
    t_score                           r_best;
    logic [NUM_EDGES-1:0][SUM_W-1:0]  r_sum;
    logic                             r_cand_vld;
    t_idx                             r_cand_idx;
    t_score                           r_cand_score;
    logic                             w_acc;
    logic                             w_cand_upd;

    assign w_acc      = r_vld[NSTAGE-1] && r_s6.member;
    assign w_cand_upd = r_vld[NSTAGE-1] && r_s6.car.uncons && !r_s6.member &&
                        (!r_cand_vld || (r_s6.car.score > r_cand_score));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_cons     <= '0;
            r_cand_vld <= 1'b0;
        end else begin
            r_vld <= {r_vld[NSTAGE-2:0], i_cmd.scan_issue};
            if (i_cmd.batch_end) begin
                r_cons <= '0;
            end else if (w_acc) begin
                r_cons[r_s6.car.idx] <= 1'b1;
            end
            if (i_cmd.load_we && (!r_cand_vld || (w_in_rec.score > r_cand_score))) begin
                r_cand_vld <= 1'b1;
            end else if (i_cmd.anc_latch || i_cmd.batch_end) begin
                r_cand_vld <= 1'b0;
            end else if (w_cand_upd) begin
                r_cand_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && (!r_cand_vld || (w_in_rec.score > r_cand_score))) begin
            r_cand_idx   <= i_cmd.wr_addr;
            r_cand_score <= w_in_rec.score;
        end else if (w_cand_upd) begin
            r_cand_idx   <= r_s6.car.idx;
            r_cand_score <= r_s6.car.score;
        end
        if (i_cmd.anc_latch) begin
            r_wgt  <= '0;
            r_best <= '0;
            r_sum  <= '0;
        end else if (w_acc) begin
            r_wgt <= r_wgt + WGT_W'(r_s6.car.score);
            if (r_s6.car.score > r_best) begin
                r_best <= r_s6.car.score;
            end
            for (int j = 0; j < NUM_EDGES; j++) begin
                r_sum[j] <= r_sum[j] + SUM_W'(r_s6.car.pe[j]);
            end
        end
    end

    // weighted mean per edge
    logic [NUM_EDGES-1:0][EDGE_W-1:0] w_quot;
    logic [NUM_EDGES-1:0]             w_busy;

    for (genvar g = 0; g < NUM_EDGES; g++) begin : g_div
        dbf_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.div_start),
            .i_dividend (r_sum[g] + SUM_W'(r_wgt >> 1)),
            .i_divisor  (r_wgt),
            .o_quot     (w_quot[g]),
            .o_busy     (w_busy[g])
        );
    end

    // result register
    logic r_out_vld;
    logic r_out_last;
    t_rec r_out;
    t_rec n_out;
    logic w_out_free;

    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_out.cls   = r_anc.cls;
        n_out.score = r_best;
        for (int j = 0; j < NUM_EDGES; j++) begin
            if (i_cmd.single) begin
                n_out.edges[j] = r_anc.edges[j];
            end else if (r_wgt == '0) begin
                n_out.edges[j] = '0;
            end else begin
                n_out.edges[j] = w_quot[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out      <= n_out;
            r_out_last <= !r_cand_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_out_last  = r_out_last;

    assign o_sts.cand_vld  = r_cand_vld;
    assign o_sts.cand_idx  = r_cand_idx;
    assign o_sts.pipe_busy = |r_vld;
    assign o_sts.div_busy  = |w_busy;
    assign o_sts.out_free  = w_out_free;

    `DBF_ASSERT_IMPL(a_div_after_drain, i_clk, i_rst_n, i_cmd.div_start, !(|r_vld))
    `DBF_ASSERT_IMPL(a_consume_once, i_clk, i_rst_n, w_acc, !r_cons[r_s6.car.idx])
    `DBF_ASSERT_IMPL(a_emit_no_overwrite, i_clk, i_rst_n, i_cmd.emit, !r_out_vld || i_out_ready)
endmodule
`default_nettype wire

FILE: rtl/detection_box_fusion_unit.sv
// Top level of the detection box fusion unit.
//
//  channel   direction  handshake                         contents
//  s_axis    in         s_axis_tvalid / s_axis_tready     one detection, tlast ends the batch
//  m_axis    out        m_axis_tvalid / m_axis_tready     one fused box, tlast on the last one
//  cfg       in         i_cfg_valid / o_cfg_ready         register index and 16-bit value
//
// Loading writes each accepted detection straight to the store. After the batch's last
// transfer, each cluster takes an anchor fetch, one store read per detection through a
// seven-stage match pipeline, and a divide.
// The single-read-port detection store sets the scan at one candidate per cycle.
// Reset is synchronous and clears control state only; no clearing pass is needed.
// A stalled output holds the next cluster after its scan; input is not taken while merging.
`default_nettype none
module detection_box_fusion_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] left_x, [31:16] top_y, [47:32] right_x, [63:48] bottom_y,
    // [79:64] confidence, [87:80] class_label
    input  wire logic [dbf_pkg::REC_W-1:0]      s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] fused_left, [31:16] fused_top, [47:32] fused_right, [63:48] fused_bottom,
    // [79:64] fused_confidence, [87:80] fused_class
    output logic      [dbf_pkg::REC_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dbf_pkg::CFG_W-1:0]      i_cfg_data
);
    import dbf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    dbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    dbf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );
endmodule
`default_nettype wire

FILE: dv/detection_box_fusion_unit_test.sv
// Self-checking testbench for the detection box fusion unit: random batches, fused box checks.
`timescale 1ns / 1ps
`default_nettype none
module detection_box_fusion_unit_test;
    import dbf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        t_edge  e[4];
        t_score score;
        t_class cls;
        logic   last;
    } t_det;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [REC_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [REC_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    detection_box_fusion_unit DUT (.*);

    initial forever #1 i_clk = ~i_clk;

    // predictor state
    logic [15:0] thr_iou = RST_IOU_LIMIT;
    logic [15:0] thr_centre = RST_CENTRE_FACTOR;
    logic [15:0] thr_area = RST_AREA_RATIO;
    t_det batch_q[$];
    t_det fused_q[$];
    t_det pending_q[$];
    int errors = 0;
    longint cycle_count = 0;

    function automatic void queue_det(t_det d);
        pending_q.insert(pending_q.size(), d);
    endfunction

    function automatic bit boxes_match(t_det a, t_det b);
        longint al, at, ar, ab, bl, bt, br, bb, iw, ih, aw, ah, bw, bh, dx, dy;
        longint unsigned inter, area_a, area_b, uni, mw, mh, ga, gb, sm, lg;
        logic [127:0] lhs, rhs;
        al = a.e[0]; at = a.e[1]; ar = a.e[2]; ab = a.e[3];
        bl = b.e[0]; bt = b.e[1]; br = b.e[2]; bb = b.e[3];
        iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl); if (iw < 0) iw = 0;
        ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt); if (ih < 0) ih = 0;
        inter = iw * ih;
        area_a = ((ar > al) ? ar - al : 0) * ((ab > at) ? ab - at : 0);
        area_b = ((br > bl) ? br - bl : 0) * ((bb > bt) ? bb - bt : 0);
        uni = area_a + area_b - inter;
        if (thr_iou == 0) return 1'b1;
        if (uni > 0 && inter * 65536 >= longint'(thr_iou) * uni) return 1'b1;
        aw = (ar - al < 1) ? 1 : ar - al; ah = (ab - at < 1) ? 1 : ab - at;
        bw = (br - bl < 1) ? 1 : br - bl; bh = (bb - bt < 1) ? 1 : bb - bt;
        mw = (aw < bw) ? aw : bw; mh = (ah < bh) ? ah : bh;
        dx = (bl + br) - (al + ar); dy = (bt + bb) - (at + ab);
        lhs = 128'(dx * dx + dy * dy) << 22;
        rhs = 128'(mw * mw + mh * mh) * 128'(longint'(thr_centre) * longint'(thr_centre));
        if (lhs > rhs) return 1'b0;
        ga = aw * ah; gb = bw * bh;
        sm = (ga < gb) ? ga : gb; lg = (ga < gb) ? gb : ga;
        return 128'(sm) * 65536 >= 128'(thr_area) * 128'(lg);
    endfunction

    task automatic fuse_batch();
        int n, k, j;
        int order[$];
        bit used[$];
        bit member[$];
        t_det r;
        longint unsigned sums[4], weight, best;
        int first_out;
        n = batch_q.size();
        first_out = fused_q.size();
        if (n == 1) begin
            r = batch_q[0];
            r.last = 1'b1;
            fused_q.insert(fused_q.size(), r);
            batch_q.delete();
            return;
        end
        for (int i = 0; i < n; i++) begin
            j = 0;
            while (j < order.size() && batch_q[order[j]].score >= batch_q[i].score) j++;
            order.insert(j, i);
            used.insert(used.size(), 1'b0);
            member.insert(member.size(), 1'b0);
        end
        for (int i = 0; i < n; i++) begin
            k = order[i];
            if (used[k]) continue;
            for (int c = 0; c < n; c++)
                member[c] = !used[c] && batch_q[c].cls == batch_q[k].cls
                    && boxes_match(batch_q[k], batch_q[c]);
            sums = '{0, 0, 0, 0}; weight = 0; best = 0;
            for (int c = 0; c < n; c++) begin
                if (!member[c]) continue;
                weight += batch_q[c].score;
                if (batch_q[c].score > best) best = batch_q[c].score;
                for (int q = 0; q < 4; q++) sums[q] += batch_q[c].score * batch_q[c].e[q];
                used[c] = 1'b1;
            end
            for (int q = 0; q < 4; q++)
                r.e[q] = (weight == 0) ? '0 : t_edge'((sums[q] + weight / 2) / weight);
            r.score = t_score'(best);
            r.cls = batch_q[k].cls;
            r.last = 1'b0;
            fused_q.insert(fused_q.size(), r);
        end
        if (fused_q.size() > first_out) fused_q[fused_q.size() - 1].last = 1'b1;
        batch_q.delete();
    endtask

    // driver
    int send_wait = 0;
    bit in_taken = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                s_axis_tvalid <= 1'b0;
                send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            end else if (!s_axis_tvalid && pending_q.size() > 0) begin
                if (send_wait > 0) send_wait--;
                else begin
                    s_axis_tdata <= {pending_q[0].cls, pending_q[0].score, pending_q[0].e[3],
                                     pending_q[0].e[2], pending_q[0].e[1], pending_q[0].e[0]};
                    s_axis_tlast <= pending_q[0].last;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end
    // transfer is flagged at the rising edge; valid drops at the next falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_det d;
            d = pending_q.pop_front();
            in_taken = 1'b1;
            if (batch_q.size() < MAX_BOXES) batch_q.insert(batch_q.size(), d);
            if (d.last) fuse_batch();
        end
    end

    // monitor
    int recv_wait = 0;
    always @(negedge i_clk) begin
        if (recv_wait > 0) begin
            recv_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (fused_q.size() == 0) begin
                $error("unexpected fused box transfer");
                errors++;
            end else begin
                t_det x;
                x = fused_q.pop_front();
                if (m_axis_tdata[15:0] !== x.e[0]) begin
                    $error("fused_left exp %0d got %0d", x.e[0], m_axis_tdata[15:0]); errors++;
                end
                if (m_axis_tdata[31:16] !== x.e[1]) begin
                    $error("fused_top exp %0d got %0d", x.e[1], m_axis_tdata[31:16]); errors++;
                end
                if (m_axis_tdata[47:32] !== x.e[2]) begin
                    $error("fused_right exp %0d got %0d", x.e[2], m_axis_tdata[47:32]); errors++;
                end
                if (m_axis_tdata[63:48] !== x.e[3]) begin
                    $error("fused_bottom exp %0d got %0d", x.e[3], m_axis_tdata[63:48]); errors++;
                end
                if (m_axis_tdata[79:64] !== x.score) begin
                    $error("fused_confidence exp %0d got %0d", x.score, m_axis_tdata[79:64]);
                    errors++;
                end
                if (m_axis_tdata[87:80] !== x.cls) begin
                    $error("fused_class exp %0d got %0d", x.cls, m_axis_tdata[87:80]); errors++;
                end
                if (m_axis_tlast !== x.last) begin
                    $error("last_cluster exp %0d got %0d", x.last, m_axis_tlast); errors++;
                end
            end
        end
        if (cycle_count > 3000000) begin
            $display("detection_box_fusion_unit verification failed");
            $finish;
        end
    end

    function automatic t_det make_det(t_edge l, t_edge t, t_edge r, t_edge b,
                                      t_score s, t_class c, logic last);
        t_det d;
        d.e[0] = l; d.e[1] = t; d.e[2] = r; d.e[3] = b;
        d.score = s; d.cls = c; d.last = last;
        return d;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_axis_tvalid || fused_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx; i_cfg_data <= val; i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_IOU_LIMIT) thr_iou = val;
        else if (idx == CFG_CENTRE_FACTOR) thr_centre = val;
        else if (idx == CFG_AREA_RATIO) thr_area = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // batch of clustered boxes around a few seeds, mostly small sizes
    task automatic queue_batch(int n, int nclass);
        t_det seeds[4];
        t_det d;
        int s, j;
        logic [15:0] x, y, w, h;
        for (j = 0; j < 4; j++) begin
            x = 16'($urandom_range(0, 60000)); y = 16'($urandom_range(0, 60000));
            w = 16'($urandom_range(1, 4000)); h = 16'($urandom_range(1, 4000));
            seeds[j] = make_det(x, y, x + w, y + h, '0,
                                t_class'($urandom_range(0, nclass - 1)), 1'b0);
        end
        for (j = 0; j < n; j++) begin
            s = $urandom_range(0, 3);
            d = seeds[s];
            if ($urandom_range(0, 9) == 0) begin
                d.e[0] = t_edge'($urandom); d.e[1] = t_edge'($urandom);
                d.e[2] = t_edge'($urandom); d.e[3] = t_edge'($urandom);
                d.cls = t_class'($urandom);
            end else begin
                for (int q = 0; q < 4; q++)
                    d.e[q] = t_edge'(d.e[q] + $urandom_range(0, 200) - 100);
            end
            d.score = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3) * 16384)
                                                   : 16'($urandom);
            d.last = (j == n - 1);
            queue_det(d);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: single, extremes, inverted, zero-weight, same scores
        queue_det(make_det(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1));
        queue_det(make_det(100, 100, 200, 200, 30000, 1, 0));
        queue_det(make_det(102, 101, 201, 199, 30000, 1, 0));
        queue_det(make_det(100, 100, 200, 200, 40000, 2, 0));
        queue_det(make_det(300, 300, 200, 200, 5, 1, 0));
        queue_det(make_det(300, 300, 300, 300, 0, 3, 0));
        queue_det(make_det(301, 300, 300, 301, 0, 3, 0));
        queue_det(make_det(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0));
        queue_det(make_det(0, 0, 0, 0, 1, 0, 1));
        wait_drained();
        write_reg(CFG_IOU_LIMIT, 16'd0);
        write_reg(CFG_UNUSED, 16'h1234);
        queue_det(make_det(0, 0, 0, 0, 0, 5, 0));
        queue_det(make_det(9000, 9000, 9100, 9100, 0, 5, 0));
        queue_det(make_det(50, 60, 70, 80, 16'hFFFF, 5, 1));
        wait_drained();
        write_reg(CFG_IOU_LIMIT, 16'hFFFF);
        write_reg(CFG_CENTRE_FACTOR, 16'hFFFF);
        write_reg(CFG_AREA_RATIO, 16'd0);
        // store overflow: 66 items, the last two dropped but the batch still merges
        for (int j = 0; j < 66; j++)
            queue_det(make_det(t_edge'($urandom), t_edge'($urandom), t_edge'($urandom),
                               t_edge'($urandom), t_score'($urandom),
                               t_class'($urandom_range(0, 3)), j == 65));
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_IOU_LIMIT, RST_IOU_LIMIT);
                    write_reg(CFG_CENTRE_FACTOR, RST_CENTRE_FACTOR);
                    write_reg(CFG_AREA_RATIO, RST_AREA_RATIO);
                end
                1: begin
                    write_reg(CFG_IOU_LIMIT, 16'd1);
                    write_reg(CFG_CENTRE_FACTOR, 16'd0);
                    write_reg(CFG_AREA_RATIO, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_IOU_LIMIT, 16'($urandom));
                    write_reg(CFG_CENTRE_FACTOR, 16'($urandom_range(0, 8000)));
                    write_reg(CFG_AREA_RATIO, 16'($urandom));
                end
                default: begin
                    write_reg(CFG_IOU_LIMIT, 16'd40000);
                    write_reg(CFG_CENTRE_FACTOR, 16'd4096);
                    write_reg(CFG_AREA_RATIO, 16'd20000);
                end
            endcase
            for (int b = 0; b < 9; b++) begin
                int n;
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
                queue_batch(n, $urandom_range(1, 3));
                while (pending_q.size() > 0) @(posedge i_clk);
            end
            wait_drained();
        end
        if (errors == 0) $display("detection_box_fusion_unit verification clean");
        else $display("detection_box_fusion_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
